### hdl/lzwve_pkg.sv
package lzwve_pkg;

    localparam int DICT_DEPTH  = 4096;
    localparam int DEPTH_BITS  = $clog2(DICT_DEPTH);
    localparam int SYMBOL_BITS = 8;
    localparam int CODE_W      = 12;
    localparam int WIDTH_W     = 4;
    localparam int NEXT_W      = 13;
    localparam int SYM_W       = 8;
    localparam int KEY_W       = CODE_W + SYMBOL_BITS;

    // open-addressed lookup table, twice the code space
    localparam int HASH_BITS   = DEPTH_BITS + 1;
    localparam int HASH_DEPTH  = 1 << HASH_BITS;
    localparam int HASH_SHIFT  = HASH_BITS - SYMBOL_BITS;

    // epoch 0 marks a cleared slot; live epochs run 1..EPOCH_MAX
    localparam int EPOCH_W     = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    localparam int MIN_RESET   = 8;
    localparam int MAX_RESET   = 12;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_DATA  = 2'd1,
        ACT_END   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [1:0] CFG_MIN_CODE = 2'd0;
    localparam logic [1:0] CFG_MAX_CODE = 2'd1;
    localparam logic [1:0] CFG_ADJUST   = 2'd2;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } tab_entry_t;

    typedef struct packed {
        logic                 we;
        logic [HASH_BITS-1:0] addr;
        tab_entry_t           data;
    } tab_wr_t;

    typedef struct packed {
        logic               last;
        logic [WIDTH_W-1:0] width;
        logic [CODE_W-1:0]  code;
    } result_t;

endpackage

### hdl/lzwve_table.sv
module lzwve_table
    import lzwve_pkg::*;
(
    input  logic                 aclk,
    input  tab_wr_t              wr,
    input  logic [HASH_BITS-1:0] raddr,
    output tab_entry_t           rdata_reg
);

    tab_entry_t mem [HASH_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

### hdl/lzwve_out_fifo.sv
module lzwve_out_fifo
    import lzwve_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  result_t    res0,
    input  result_t    res1,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data,
    output logic       space2
);

    result_t    buf_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign space2    = (cnt_reg <= 3'd2);
    assign pop       = out_valid & out_ready;

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            buf_reg[wr_ptr_reg] <= res0;
        end
        if (push_cnt == 2'd2) begin
            buf_reg[wr_ptr_reg + 2'd1] <= res1;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_cnt;
            rd_ptr_reg <= rd_ptr_reg + 2'(pop);
            cnt_reg    <= cnt_reg + 3'(push_cnt) - 3'(pop);
        end
    end

endmodule

### hdl/lzw_variable_width_encoder.sv
// channel  | ports                          | contents (low bit first)
// s_       | s_tvalid s_tready s_tdata s_tuser | tdata: symbol[7:0]; tuser: action[1:0]
// m_       | m_tvalid m_tready m_tdata m_tlast | tdata: code[11:0] code_width[15:12]
// cfg_     | cfg_valid cfg_ready cfg_index cfg_data | index 0 min, 1 max, 2 adjust
//
// Start, end and a stream's first symbol are taken in ST_IDLE, with no lookup.
// A data symbol that needs a lookup probes the hash table in ST_LOOK (one read
// port, registered data) slot after slot until a hit or an empty slot. An end
// that flushes a match goes on through ST_FIX and ST_PATCH to put the skipped
// code's old pair back in the hash table. After reset, and on every 255th
// dictionary clear, a clearing pass over all hash table slots runs with s_tready
// low; the pass after reset also zeroes the code-indexed dictionary. A four-word
// result queue keeps input flowing while m_tready is low, until three words wait.
module lzw_variable_width_encoder
    import lzwve_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol[7:0]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // code[11:0], code_width[15:12]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_LOOK, ST_FIX, ST_PATCH} state_t;

    state_t               state_reg, state_next;
    logic [3:0]           min_reg, max_reg;
    logic [1:0]           adj_reg;
    logic [NEXT_W-1:0]    next_code_reg, next_code_next;
    logic [WIDTH_W-1:0]   width_reg, width_next;
    logic [CODE_W-1:0]    pend_code_reg, pend_code_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [HASH_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                 init_reg, init_next;
    logic [HASH_BITS-1:0] probe_reg, probe_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;
    logic [KEY_W-1:0]     key_reg, key_next;

    // code-indexed copy of every inserted pair
    logic [KEY_W-1:0]     dict_mem [DICT_DEPTH];
    logic [KEY_W-1:0]     dict_rd_reg;
    logic                 dict_we;
    logic [DEPTH_BITS-1:0] dict_waddr;
    logic [KEY_W-1:0]     dict_wdata;

    logic [3:0]           eff_m, eff_x;
    logic [1:0]           eff_adj;
    logic [CODE_W-1:0]    clear_code;
    logic [SYM_W-1:0]     sym_in;
    logic [HASH_BITS-1:0] hash_in, raddr;
    tab_entry_t           rd_entry;
    tab_wr_t              tab_wr;
    logic                 accept, space2;
    logic [1:0]           push_cnt;
    result_t              res0, res1, out_res;
    logic                 ent_live, ent_hit;
    logic [NEXT_W-1:0]    nc;
    logic [WIDTH_W-1:0]   w1;
    logic                 do_reset;

    function automatic logic [HASH_BITS-1:0] hash_of(logic [KEY_W-1:0] k);
        return HASH_BITS'(k[KEY_W-1:SYMBOL_BITS])
             ^ HASH_BITS'(HASH_BITS'(k[SYMBOL_BITS-1:0]) << HASH_SHIFT);
    endfunction

    assign cfg_ready = 1'b1;

    always_comb begin
        eff_m = min_reg;
        if (eff_m > 4'(SYMBOL_BITS)) eff_m = 4'(SYMBOL_BITS);
        if ({1'b0, eff_m} + 5'd1 > 5'(DEPTH_BITS)) eff_m = 4'(DEPTH_BITS - 1);
        if (eff_m < 4'd2) eff_m = 4'd2;
        eff_x = max_reg;
        if (eff_x > 4'(DEPTH_BITS)) eff_x = 4'(DEPTH_BITS);
        if ({1'b0, eff_x} < {1'b0, eff_m} + 5'd1) eff_x = eff_m + 4'd1;
        eff_adj = (adj_reg == 2'd3) ? 2'd2 : adj_reg;
    end

    assign clear_code = CODE_W'(1) << eff_m;
    assign sym_in     = s_tdata & SYM_W'(clear_code - CODE_W'(1));
    assign hash_in    = hash_of({pend_code_reg, sym_in});
    assign raddr      = (state_reg == ST_LOOK || state_reg == ST_PATCH)
                      ? probe_reg + HASH_BITS'(1)
                      : (state_reg == ST_FIX) ? hash_of(dict_rd_reg) : hash_in;
    assign s_tready   = (state_reg == ST_IDLE) && space2;
    assign accept     = s_tvalid && s_tready;

    lzwve_table u_table (
        .aclk      (aclk),
        .wr        (tab_wr),
        .raddr     (raddr),
        .rdata_reg (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (dict_we) begin
            dict_mem[dict_waddr] <= dict_wdata;
        end
        dict_rd_reg <= dict_mem[next_code_reg[DEPTH_BITS-1:0]];
    end

    // lookup and insert arithmetic
    always_comb begin
        ent_live = (rd_entry.epoch == epoch_reg);
        ent_hit  = ent_live && (rd_entry.key == key_reg)
                && ({1'b0, rd_entry.code} >= NEXT_W'(clear_code) + NEXT_W'(2))
                && ({1'b0, rd_entry.code} < next_code_reg);
        nc = next_code_reg + NEXT_W'(1);
        w1 = width_reg;
        if (width_reg < eff_x
            && {1'b0, nc} >= (14'(1) << width_reg) + 14'd1 - 14'(eff_adj)) begin
            w1 = width_reg + 4'd1;
        end
        do_reset = (w1 >= eff_x)
                && ({1'b0, nc} >= (14'(1) << eff_x) + 14'd1 - 14'(eff_adj));
    end

    always_comb begin
        state_next      = state_reg;
        next_code_next  = next_code_reg;
        width_next      = width_reg;
        pend_code_next  = pend_code_reg;
        pend_valid_next = pend_valid_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        init_next       = init_reg;
        probe_next      = probe_reg;
        sym_next        = sym_reg;
        key_next        = key_reg;
        push_cnt        = 2'd0;
        res0            = '{last: 1'b1, width: width_reg, code: pend_code_reg};
        res1            = '{last: 1'b1, width: width_reg, code: clear_code + CODE_W'(1)};
        tab_wr          = '{we: 1'b0, addr: probe_reg,
                            data: '{epoch: epoch_reg, key: key_reg,
                                    code: CODE_W'(next_code_reg)}};
        dict_we         = 1'b0;
        dict_waddr      = next_code_reg[DEPTH_BITS-1:0];
        dict_wdata      = key_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                tab_wr.we   = 1'b1;
                tab_wr.addr = clr_addr_reg;
                tab_wr.data = '0;
                if (init_reg) begin
                    dict_we    = 1'b1;
                    dict_waddr = clr_addr_reg[DEPTH_BITS-1:0];
                    dict_wdata = '0;
                end
                clr_addr_next = clr_addr_reg + HASH_BITS'(1);
                if (clr_addr_reg == HASH_BITS'(HASH_DEPTH - 1)) begin
                    init_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (action_t'(s_tuser))
                        ACT_START: begin
                            next_code_next  = NEXT_W'(clear_code) + NEXT_W'(2);
                            width_next      = eff_m + 4'd1;
                            pend_valid_next = 1'b0;
                            push_cnt        = 2'd1;
                            res0 = '{last: 1'b1, width: eff_m + 4'd1, code: clear_code};
                            if (epoch_reg == EPOCH_MAX) begin
                                epoch_next = EPOCH_W'(1);
                                state_next = ST_CLEAR;
                            end else begin
                                epoch_next = epoch_reg + EPOCH_W'(1);
                            end
                        end
                        ACT_END: begin
                            if (pend_valid_reg) begin
                                push_cnt        = 2'd2;
                                res0.last       = 1'b0;
                                next_code_next  = next_code_reg + NEXT_W'(1);
                                pend_valid_next = 1'b0;
                                // skipped code keeps its old pair, still matchable
                                if (next_code_reg < NEXT_W'(DICT_DEPTH)) begin
                                    state_next = ST_FIX;
                                end
                            end else begin
                                push_cnt = 2'd1;
                                res0     = res1;
                            end
                        end
                        ACT_DATA: begin
                            if (!pend_valid_reg) begin
                                pend_code_next  = CODE_W'(sym_in);
                                pend_valid_next = 1'b1;
                            end else begin
                                key_next   = {pend_code_reg, SYMBOL_BITS'(sym_in)};
                                sym_next   = sym_in;
                                probe_next = hash_in;
                                state_next = ST_LOOK;
                            end
                        end
                        ACT_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOOK: begin
                priority if (ent_hit) begin
                    pend_code_next = rd_entry.code;
                    state_next     = ST_IDLE;
                end else if (!ent_live) begin
                    // miss: emit prefix, insert pair at next code
                    tab_wr.we      = (next_code_reg < NEXT_W'(DICT_DEPTH));
                    dict_we        = (next_code_reg < NEXT_W'(DICT_DEPTH));
                    pend_code_next = CODE_W'(sym_reg);
                    state_next     = ST_IDLE;
                    if (do_reset) begin
                        push_cnt       = 2'd2;
                        res0.last      = 1'b0;
                        res1           = '{last: 1'b1, width: w1, code: clear_code};
                        next_code_next = NEXT_W'(clear_code) + NEXT_W'(2);
                        width_next     = eff_m + 4'd1;
                        if (epoch_reg == EPOCH_MAX) begin
                            epoch_next = EPOCH_W'(1);
                            state_next = ST_CLEAR;
                        end else begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end else begin
                        push_cnt       = 2'd1;
                        next_code_next = nc;
                        width_next     = w1;
                    end
                end else begin
                    probe_next = probe_reg + HASH_BITS'(1);
                end
            end
            ST_FIX: begin
                key_next   = dict_rd_reg;
                probe_next = hash_of(dict_rd_reg);
                state_next = ST_PATCH;
            end
            ST_PATCH: begin
                // a lower code with the same pair wins, so only fill an empty slot
                priority if (ent_hit) begin
                    state_next = ST_IDLE;
                end else if (!ent_live) begin
                    tab_wr.we        = 1'b1;
                    tab_wr.data.code = CODE_W'(next_code_reg - NEXT_W'(1));
                    state_next       = ST_IDLE;
                end else begin
                    probe_next = probe_reg + HASH_BITS'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        probe_reg <= probe_next;
        sym_reg   <= sym_next;
        key_reg   <= key_next;
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            min_reg        <= 4'(MIN_RESET);
            max_reg        <= 4'(MAX_RESET);
            adj_reg        <= '0;
            next_code_reg  <= NEXT_W'((1 << MIN_RESET) + 2);
            width_reg      <= WIDTH_W'(MIN_RESET + 1);
            pend_code_reg  <= '0;
            pend_valid_reg <= 1'b0;
            epoch_reg      <= EPOCH_W'(1);
            clr_addr_reg   <= '0;
            init_reg       <= 1'b1;
        end else begin
            state_reg      <= state_next;
            next_code_reg  <= next_code_next;
            width_reg      <= width_next;
            pend_code_reg  <= pend_code_next;
            pend_valid_reg <= pend_valid_next;
            epoch_reg      <= epoch_next;
            clr_addr_reg   <= clr_addr_next;
            init_reg       <= init_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MIN_CODE: min_reg <= cfg_data;
                    CFG_MAX_CODE: max_reg <= cfg_data;
                    CFG_ADJUST:   adj_reg <= cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    lzwve_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res),
        .space2    (space2)
    );

    assign m_tdata = {out_res.width, out_res.code};
    assign m_tlast = out_res.last;

endmodule

### hdl/lzwve_checker.sv
module lzwve_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a word held back keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // reset starts the table clearing pass, so no input is taken
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("ready or valid right after reset");

    a_width: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:12] >= 4'd3 && m_tdata[15:12] <= 4'd12)
        else $error("code width out of range");

    // code never wider than its width field
    a_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:0] >> m_tdata[15:12]) == 12'd0)
        else $error("code exceeds its width");

endmodule

bind lzw_variable_width_encoder lzwve_checker u_lzwve_checker (.*);

### bench/lzw_variable_width_encoder_test.sv
`timescale 1ns / 1ps

module lzw_variable_width_encoder_test;
    import lzwve_pkg::*;

    // Tracks the encoder's dictionary and queues the codes it must emit.
    class lzw_code_tracker;
        logic [KEY_W-1:0]  dict [DICT_DEPTH];
        logic [NEXT_W-1:0] next_code;
        logic [3:0]        width_now;
        logic [CODE_W-1:0] pend_code;
        bit                pend_valid;
        logic [3:0]        min_reg;
        logic [3:0]        max_reg;
        logic [1:0]        adj_reg;
        result_t           expected_codes [$];
        int                errors;
        int                words_in;
        int                words_out;
        int                clears_seen;

        function new();
            min_reg = 4'(MIN_RESET);
            max_reg = 4'(MAX_RESET);
            adj_reg = '0;
            pend_code = '0;
            pend_valid = 0;
            errors = 0;
            words_in = 0;
            words_out = 0;
            clears_seen = 0;
            foreach (dict[i]) dict[i] = '0;
            restart_table();
        endfunction

        function int sym_bits();
            int m;
            m = min_reg;
            if (m > SYMBOL_BITS) m = SYMBOL_BITS;
            if (m + 1 > DEPTH_BITS) m = DEPTH_BITS - 1;
            if (m < 2) m = 2;
            return m;
        endfunction

        function int top_width();
            int x;
            x = max_reg;
            if (x > DEPTH_BITS) x = DEPTH_BITS;
            if (x < sym_bits() + 1) x = sym_bits() + 1;
            return x;
        endfunction

        function void restart_table();
            next_code = NEXT_W'((1 << sym_bits()) + 2);
            width_now = 4'(sym_bits() + 1);
        endfunction

        function void push(int code, int width, bit last);
            result_t r;
            r.code = CODE_W'(code);
            r.width = WIDTH_W'(width);
            r.last = last;
            expected_codes.push_back(r);
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] val);
            if (idx == CFG_MIN_CODE) min_reg = val;
            else if (idx == CFG_MAX_CODE) max_reg = val;
            else if (idx == CFG_ADJUST) adj_reg = val[1:0];
        endfunction

        function void note_word(action_t act, logic [7:0] sym_in);
            int clear, sym, c, hi, maxw, adj, w0;
            logic [KEY_W-1:0] key;
            bit hit;
            words_in++;
            clear = 1 << sym_bits();
            hit = 0;
            case (act)
                ACT_START: begin
                    restart_table();
                    pend_valid = 0;
                    push(clear, width_now, 1);
                end
                ACT_END: begin
                    if (pend_valid) begin
                        push(pend_code, width_now, 0);
                        next_code = next_code + 13'd1;
                        pend_valid = 0;
                    end
                    push(clear + 1, width_now, 1);
                end
                ACT_DATA: begin
                    sym = sym_in & (clear - 1);
                    if (!pend_valid) begin
                        pend_code = CODE_W'(sym);
                        pend_valid = 1;
                    end else begin
                        key = {pend_code, sym[7:0]};
                        hi = (next_code < DICT_DEPTH) ? next_code : DICT_DEPTH;
                        for (c = clear + 2; c < hi && !hit; c++) begin
                            if (dict[c] == key) begin
                                pend_code = CODE_W'(c);
                                hit = 1;
                            end
                        end
                        if (!hit) begin
                            maxw = top_width();
                            adj = (adj_reg > 2) ? 2 : adj_reg;
                            if (next_code < DICT_DEPTH) dict[next_code] = key;
                            // the prefix goes out at the width before any growth
                            w0 = width_now;
                            next_code = next_code + 13'd1;
                            if (width_now < maxw && next_code >= (1 << width_now) + 1 - adj)
                                width_now++;
                            if (width_now >= maxw && next_code >= (1 << maxw) + 1 - adj) begin
                                push(pend_code, w0, 0);
                                push(clear, width_now, 1);
                                clears_seen++;
                                restart_table();
                            end else begin
                                push(pend_code, w0, 1);
                            end
                            pend_code = CODE_W'(sym);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [11:0] code, logic [3:0] width, logic last);
            result_t e;
            words_out++;
            if (expected_codes.size() == 0) begin
                $error("unexpected code word %0d width %0d", code, width);
                errors++;
                return;
            end
            e = expected_codes.pop_front();
            if (code !== e.code) begin
                $error("code: expected %0d, got %0d", e.code, code);
                errors++;
            end
            if (width !== e.width) begin
                $error("code_width: expected %0d, got %0d", e.width, width);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;

    lzw_code_tracker tracker;
    bit              busy_rx;

    lzw_variable_width_encoder dut (.*);

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #6000000;
        $display("lzw_variable_width_encoder test failed");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: stall bursts alternate with stretches of full readiness
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (busy_rx) m_tready <= ($urandom_range(0, 99) < 60);
        else m_tready <= 1'b1;
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) busy_rx <= ~busy_rx;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_word(m_tdata[11:0], m_tdata[15:12], m_tlast);
    end

    // called at a falling edge, returns at a falling edge
    task send_word(action_t act, logic [7:0] sym);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= sym;
        do @(posedge aclk); while (!s_tready);
        tracker.note_word(act, sym);
        @(negedge aclk);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        while (tracker.expected_codes.size() != 0) @(negedge aclk);
        // lookups that emit nothing may still be in flight
        repeat (64) @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task set_config(logic [3:0] mn, logic [3:0] mx, logic [3:0] adj);
        drain();
        write_reg(CFG_MIN_CODE, mn);
        write_reg(CFG_MAX_CODE, mx);
        write_reg(CFG_ADJUST, adj);
        cfg_valid <= 1'b0;
    endtask

    // a stream: start, mostly repetitive symbols so matches build up, with stray none, end and start words, then end
    task random_stream(int n);
        int alpha, r;
        logic [7:0] s;
        send_word(ACT_START, 8'($urandom));
        alpha = $urandom_range(1, 1 << tracker.sym_bits());
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 3) send_word(ACT_NONE, 8'($urandom));
            else if (r < 6) send_word(ACT_END, 8'($urandom));
            else if (r < 8) send_word(ACT_START, 8'($urandom));
            else begin
                s = (r < 15) ? 8'($urandom) : 8'($urandom_range(0, alpha - 1));
                send_word(ACT_DATA, s);
            end
        end
        send_word(ACT_END, 8'($urandom));
    endtask

    initial begin
        tracker = new();
        busy_rx = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = ACT_NONE;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_CODE;
        cfg_data = '0;
        m_tready = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: data before any start, end with and without a match
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_DATA, 8'hff);
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_END, 8'h00);
        send_word(ACT_END, 8'h00);
        send_word(ACT_DATA, 8'h41);
        send_word(ACT_NONE, 8'h41);
        send_word(ACT_START, 8'h00);
        send_word(ACT_DATA, 8'h41);
        send_word(ACT_DATA, 8'h41);
        send_word(ACT_DATA, 8'h41);
        send_word(ACT_DATA, 8'h41);
        send_word(ACT_START, 8'h00);
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_DATA, 8'h00);
        send_word(ACT_END, 8'h00);

        // smallest codes, widest early change: table wraps almost at once
        set_config(4'd2, 4'd3, 4'd2);
        send_word(ACT_START, 8'h00);
        for (int i = 0; i < 6; i++) send_word(ACT_DATA, 8'hfc | i[1:0]);
        send_word(ACT_END, 8'h00);
        random_stream(90);

        set_config(4'd4, 4'd6, 4'd1);
        random_stream(50);
        drain(); // hold the sender until everything is out
        random_stream(50);

        // out-of-range register values get clamped
        set_config(4'd15, 4'd0, 4'd3);
        random_stream(60);

        set_config(4'd3, 4'd15, 4'd0);
        random_stream(60);

        set_config(4'd8, 4'd12, 4'd0);
        random_stream(60);

        drain();
        repeat (200) @(posedge aclk);
        $display("covered %0d input words, %0d code words, %0d table wraps",
                 tracker.words_in, tracker.words_out, tracker.clears_seen);
        $display("configs: min 2..15, max 0..15, early change 0..3");
        if (tracker.errors == 0 && tracker.expected_codes.size() == 0)
            $display("lzw_variable_width_encoder test passed");
        else
            $display("lzw_variable_width_encoder test failed");
        $finish;
    end
endmodule
